/* rtl/m32s_pkg.sv */
// package: opcodes, function codes, sequencer states and constants for the instruction step core
package m32s_pkg;

  localparam logic [31:0] START_PC_RST  = 32'h0040_0000;
  localparam logic [31:0] DATA_BASE_RST = 32'h1000_0000;
  localparam int unsigned DMEM_WORDS_DEF = 4096;
  localparam logic [31:0] EXIT_CODE     = 32'h0000_000A;

  localparam logic [0:0] CFG_START_PC  = 1'b0;
  localparam logic [0:0] CFG_DATA_BASE = 1'b1;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;

  localparam logic [4:0] RT_BLTZ   = 5'h00;
  localparam logic [4:0] RT_BGEZ   = 5'h01;
  localparam logic [4:0] RT_BLTZAL = 5'h10;
  localparam logic [4:0] RT_BGEZAL = 5'h11;
  localparam logic [4:0] REG_V0    = 5'd2;
  localparam logic [4:0] REG_RA    = 5'd31;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ_A,
    ST_READ_B,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_DIV_FIX,
    ST_MEM,
    ST_WB,
    ST_OUT
  } state_t;

endpackage

/* rtl/mips32_instruction_step.sv */
// top level: multi-cycle MIPS32 integer instruction step core
//
// usage:
//   in_valid/in_stall carry one instruction word fetched at the current pc;
//   a transfer happens when valid is high and stall low. the core holds
//   in_stall high from the transfer until its result has been taken.
//   out_valid/out_stall carry one result per instruction: next pc, register
//   write, hi/lo, memory write, halted and unknown-instruction flags.
//   cfg_we/cfg_index/cfg_wdata write start_pc (index 0, also loads the pc)
//   or data_base (index 1). the user must write them only while the core
//   is idle; the core itself does not enforce this.
// sequence:
//   ordinary instructions read rs, read rt, execute and write back; loads
//   and stores add a step (one data memory read port), mult/multu four
//   16x16 partial products on one shared multiplier, div/divu (nonzero
//   divisor) one quotient bit per cycle on the shared subtractor plus a
//   sign fix. a new item waits for the cycle after the out transfer.
// reset: registers, hi, lo and halt clear, pc loads start_pc; data memory
//   is not cleared. while out_stall is high the result holds steady.
module mips32_instruction_step #(
  parameter int unsigned DMEM_WORDS = m32s_pkg::DMEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instruction_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_next_pc,
  output logic        out_reg_write_valid,
  output logic [4:0]  out_reg_write_index,
  output logic [31:0] out_reg_write_value,
  output logic [31:0] out_hi_value,
  output logic [31:0] out_lo_value,
  output logic        out_mem_write_valid,
  output logic [31:0] out_mem_write_address,
  output logic [31:0] out_mem_write_value,
  output logic        out_halted,
  output logic        out_unknown_instruction,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import m32s_pkg::*;

  localparam int unsigned AW = (DMEM_WORDS > 1) ? $clog2(DMEM_WORDS) : 1;
  localparam logic [33:0] DMEM_BYTES = 34'(DMEM_WORDS) << 2;

  state_t state_r, state_nxt;

  logic [31:0] rf [32];
  logic [31:0] dmem [DMEM_WORDS];

  logic [31:0] start_pc_r, data_base_r, pc_r, hi_r, lo_r;
  logic        halt_r;
  logic [31:0] inst_r, a_r, b_r, v0_r;
  logic [4:0]  rf_raddr;
  logic [31:0] rf_rdata;
  logic [31:0] rf_vld_r;
  logic        rd_vld_r;
  logic [31:0] rf_q, b_val;

  logic [31:0] res_r, res_nxt, npc_r, npc_nxt;
  logic [4:0]  widx_r, widx_nxt;
  logic        unk_r, unk_nxt;
  logic [1:0]  cnt_r;
  logic [5:0]  dcnt_r;

  // shared multiplier and divider datapath
  logic [63:0] acc_r;
  logic [31:0] ma_r, mb_r;
  logic        mneg_r;
  logic [15:0] mul_x, mul_y;
  logic [31:0] mul_p;
  logic [63:0] mul_sh;
  logic [31:0] rem_r, quo_r;
  logic        dna_r, dnb_r;
  logic [32:0] dsub;
  logic [31:0] drem;

  logic [31:0] mem_rd_r;
  logic [AW-1:0] slot_r;
  logic          inr_r;

  logic        o_valid_r, o_wv_r, o_mv_r, o_halt_r, o_unk_r;
  logic [31:0] o_npc_r, o_wval_r, o_ma_r, o_mval_r;
  logic [4:0]  o_wi_r;

  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [31:0] imm, simm, pc4, btarget, addr, off;
  logic        in_xfer, out_xfer, is_load, is_store, in_range, exit_hit;
  logic [31:0] load_res, store_w;

  assign op   = inst_r[31:26];
  assign fn   = inst_r[5:0];
  assign rs   = inst_r[25:21];
  assign rt   = inst_r[20:16];
  assign rd   = inst_r[15:11];
  assign sh   = inst_r[10:6];
  assign imm  = {16'h0, inst_r[15:0]};
  assign simm = {{16{inst_r[15]}}, inst_r[15:0]};
  assign pc4  = pc_r + 32'd4;
  assign btarget = pc4 + {simm[29:0], 2'b00};
  assign addr = a_r + simm;
  assign off  = addr - data_base_r;
  assign in_range = {2'b00, off} < DMEM_BYTES;
  assign is_load  = (op == OP_LB) || (op == OP_LH) || (op == OP_LW) ||
                    (op == OP_LBU) || (op == OP_LHU);
  assign is_store = (op == OP_SB) || (op == OP_SH) || (op == OP_SW);
  assign exit_hit = (op == OP_SPECIAL) && (fn == FN_SYSCALL) && (v0_r == EXIT_CODE);

  // unwritten registers read as zero; rt operand arrives during execute
  assign rf_q  = rd_vld_r ? rf_rdata : 32'h0;
  assign b_val = (state_r == ST_EXEC) ? ((rt == 5'd0) ? 32'h0 : rf_q) : b_r;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = o_valid_r && !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_xfer) state_nxt = ST_READ_A;
      ST_READ_A:  state_nxt = ST_READ_B;
      ST_READ_B:  state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (halt_r) state_nxt = ST_WB;
        else if (op == OP_SPECIAL && (fn == FN_MULT || fn == FN_MULTU))
          state_nxt = ST_MUL;
        else if (op == OP_SPECIAL && (fn == FN_DIV || fn == FN_DIVU) && b_val != 32'h0)
          state_nxt = ST_DIV;
        else if (is_load || is_store) state_nxt = ST_MEM;
        else state_nxt = ST_WB;
      end
      ST_MUL:     if (cnt_r == 2'd3) state_nxt = ST_WB;
      ST_DIV:     if (dcnt_r == 6'd31) state_nxt = ST_DIV_FIX;
      ST_DIV_FIX: state_nxt = ST_WB;
      ST_MEM:     state_nxt = ST_WB;
      ST_WB:      state_nxt = ST_OUT;
      ST_OUT:     if (out_xfer) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_READ_A: rf_raddr = rs;
      ST_READ_B: rf_raddr = rt;
      default:   rf_raddr = REG_V0;
    endcase
  end

  always_ff @(posedge clk) begin
    rf_rdata <= rf[rf_raddr];
  end

  // execute decode
  always_comb begin
    res_nxt  = 32'h0;
    npc_nxt  = pc4;
    widx_nxt = 5'd0;
    unk_nxt  = 1'b0;
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL:  begin widx_nxt = rd; res_nxt = b_val << sh; end
          FN_SRL:  begin widx_nxt = rd; res_nxt = b_val >> sh; end
          FN_SRA:  begin widx_nxt = rd; res_nxt = 32'($signed(b_val) >>> sh); end
          FN_SLLV: begin widx_nxt = rd; res_nxt = b_val << a_r[4:0]; end
          FN_SRLV: begin widx_nxt = rd; res_nxt = b_val >> a_r[4:0]; end
          FN_SRAV: begin widx_nxt = rd; res_nxt = 32'($signed(b_val) >>> a_r[4:0]); end
          FN_JR:   npc_nxt = a_r;
          FN_JALR: begin widx_nxt = rd; res_nxt = pc4; npc_nxt = a_r; end
          FN_SYSCALL, FN_MTHI, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: ;
          FN_MFHI: begin widx_nxt = rd; res_nxt = hi_r; end
          FN_MFLO: begin widx_nxt = rd; res_nxt = lo_r; end
          FN_ADD, FN_ADDU: begin widx_nxt = rd; res_nxt = a_r + b_val; end
          FN_SUB, FN_SUBU: begin widx_nxt = rd; res_nxt = a_r - b_val; end
          FN_AND:  begin widx_nxt = rd; res_nxt = a_r & b_val; end
          FN_OR:   begin widx_nxt = rd; res_nxt = a_r | b_val; end
          FN_XOR:  begin widx_nxt = rd; res_nxt = a_r ^ b_val; end
          FN_NOR:  begin widx_nxt = rd; res_nxt = ~(a_r | b_val); end
          FN_SLT:  begin widx_nxt = rd; res_nxt = {31'h0, $signed(a_r) < $signed(b_val)}; end
          FN_SLTU: begin widx_nxt = rd; res_nxt = {31'h0, a_r < b_val}; end
          default: unk_nxt = 1'b1;
        endcase
      end
      OP_REGIMM: begin
        case (rt)
          RT_BLTZ: if (a_r[31]) npc_nxt = btarget;
          RT_BGEZ: if (!a_r[31]) npc_nxt = btarget;
          RT_BLTZAL: begin
            widx_nxt = REG_RA; res_nxt = pc4;
            if (a_r[31]) npc_nxt = btarget;
          end
          RT_BGEZAL: begin
            widx_nxt = REG_RA; res_nxt = pc4;
            if (!a_r[31]) npc_nxt = btarget;
          end
          default: unk_nxt = 1'b1;
        endcase
      end
      OP_J:    npc_nxt = {pc4[31:28], inst_r[25:0], 2'b00};
      OP_JAL: begin
        widx_nxt = REG_RA; res_nxt = pc4;
        npc_nxt = {pc4[31:28], inst_r[25:0], 2'b00};
      end
      OP_BEQ:  if (a_r == b_val) npc_nxt = btarget;
      OP_BNE:  if (a_r != b_val) npc_nxt = btarget;
      OP_BLEZ: if (a_r == 32'h0 || a_r[31]) npc_nxt = btarget;
      OP_BGTZ: if (a_r != 32'h0 && !a_r[31]) npc_nxt = btarget;
      OP_ADDI, OP_ADDIU: begin widx_nxt = rt; res_nxt = a_r + simm; end
      OP_SLTI:  begin widx_nxt = rt; res_nxt = {31'h0, $signed(a_r) < $signed(simm)}; end
      OP_SLTIU: begin widx_nxt = rt; res_nxt = {31'h0, a_r < simm}; end
      OP_ANDI:  begin widx_nxt = rt; res_nxt = a_r & imm; end
      OP_ORI:   begin widx_nxt = rt; res_nxt = a_r | imm; end
      OP_XORI:  begin widx_nxt = rt; res_nxt = a_r ^ imm; end
      OP_LUI:   begin widx_nxt = rt; res_nxt = {inst_r[15:0], 16'h0}; end
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: widx_nxt = rt;
      OP_SB, OP_SH, OP_SW: ;
      default: unk_nxt = 1'b1;
    endcase
  end

  // load extraction and store merge from the word read
  always_comb begin
    logic [31:0] w;
    logic [7:0]  by;
    logic [15:0] hw;
    w  = inr_r ? mem_rd_r : 32'h0;
    by = w[8*addr[1:0] +: 8];
    hw = w[16*addr[1] +: 16];
    case (op)
      OP_LB:   load_res = {{24{by[7]}}, by};
      OP_LBU:  load_res = {24'h0, by};
      OP_LH:   load_res = {{16{hw[15]}}, hw};
      OP_LHU:  load_res = {16'h0, hw};
      default: load_res = w;
    endcase
    store_w = mem_rd_r;
    case (op)
      OP_SB:   store_w[8*addr[1:0] +: 8] = b_r[7:0];
      OP_SH:   store_w[16*addr[1] +: 16] = b_r[15:0];
      default: store_w = b_r;
    endcase
  end

  assign mul_x  = cnt_r[0] ? ma_r[31:16] : ma_r[15:0];
  assign mul_y  = cnt_r[1] ? mb_r[31:16] : mb_r[15:0];
  assign mul_p  = mul_x * mul_y;
  assign mul_sh = {32'h0, mul_p} << {2'(cnt_r[1]) + 2'(cnt_r[0]), 4'h0};
  assign dsub   = {rem_r, quo_r[31]} - {1'b0, mb_r};
  assign drem   = {rem_r[30:0], quo_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      start_pc_r <= START_PC_RST;
      data_base_r <= DATA_BASE_RST;
      pc_r       <= START_PC_RST;
      hi_r       <= 32'h0;
      lo_r       <= 32'h0;
      halt_r     <= 1'b0;
      o_valid_r  <= 1'b0;
      cnt_r      <= 2'd0;
      dcnt_r     <= 6'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_PC: begin start_pc_r <= cfg_wdata; pc_r <= cfg_wdata; end
          CFG_DATA_BASE: data_base_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == ST_EXEC && !halt_r && op == OP_SPECIAL) begin
        case (fn)
          FN_MTHI: hi_r <= a_r;
          FN_MTLO: lo_r <= a_r;
          default: ;
        endcase
      end
      cnt_r  <= (state_r == ST_MUL) ? cnt_r + 2'd1 : 2'd0;
      dcnt_r <= (state_r == ST_DIV) ? dcnt_r + 6'd1 : 6'd0;
      if (state_r == ST_MUL && cnt_r == 2'd3) begin
        {hi_r, lo_r} <= mneg_r ? 64'h0 - (acc_r + mul_sh) : acc_r + mul_sh;
      end
      if (state_r == ST_DIV_FIX) begin
        lo_r <= (dna_r != dnb_r) ? 32'h0 - quo_r : quo_r;
        hi_r <= dna_r ? 32'h0 - rem_r : rem_r;
      end
      if (state_r == ST_WB && !halt_r && exit_hit) halt_r <= 1'b1;
      if (state_r == ST_WB && !halt_r) pc_r <= npc_r;
      if (state_r == ST_WB) o_valid_r <= 1'b1;
      else if (out_xfer) o_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) inst_r <= in_instruction_word;
    if (state_r == ST_READ_A) v0_r <= rf_q;
    if (state_r == ST_READ_B) a_r <= (rs == 5'd0) ? 32'h0 : rf_q;
    if (state_r == ST_EXEC) begin
      b_r    <= b_val;
    end
    if (state_r == ST_EXEC) begin
      res_r  <= res_nxt;
      npc_r  <= npc_nxt;
      widx_r <= widx_nxt;
      unk_r  <= unk_nxt;
      slot_r <= off[AW+1:2];
      inr_r  <= in_range;
      acc_r  <= 64'h0;
      rem_r  <= 32'h0;
      dna_r  <= (fn == FN_DIV) && a_r[31];
      dnb_r  <= (fn == FN_DIV) && b_val[31];
      mneg_r <= (fn == FN_MULT) && (a_r[31] ^ b_val[31]);
      ma_r   <= ((fn == FN_MULT || fn == FN_DIV) && a_r[31]) ? 32'h0 - a_r : a_r;
      quo_r  <= ((fn == FN_MULT || fn == FN_DIV) && a_r[31]) ? 32'h0 - a_r : a_r;
      mb_r   <= ((fn == FN_MULT || fn == FN_DIV) && b_val[31]) ? 32'h0 - b_val : b_val;
    end
    if (state_r == ST_MUL) acc_r <= acc_r + mul_sh;
    if (state_r == ST_DIV) begin
      rem_r <= dsub[32] ? drem : dsub[31:0];
      quo_r <= {quo_r[30:0], ~dsub[32]};
    end
    if (state_r == ST_MEM) begin
      mem_rd_r <= dmem[slot_r];
    end
    if (state_r == ST_WB) begin
      o_npc_r  <= halt_r ? pc_r : npc_r;
      o_halt_r <= halt_r || exit_hit;
      o_unk_r  <= !halt_r && unk_r;
      o_wv_r   <= !halt_r && widx_r != 5'd0;
      o_wi_r   <= (!halt_r && widx_r != 5'd0) ? widx_r : 5'd0;
      o_wval_r <= (!halt_r && widx_r != 5'd0) ? (is_load ? load_res : res_r) : 32'h0;
      o_mv_r   <= !halt_r && is_store && inr_r;
      o_ma_r   <= (!halt_r && is_store && inr_r) ? {addr[31:2], 2'b00} : 32'h0;
      o_mval_r <= (!halt_r && is_store && inr_r) ? store_w : 32'h0;
      if (!halt_r && is_store && inr_r) dmem[slot_r] <= store_w;
      if (!halt_r && widx_r != 5'd0) rf[widx_r] <= is_load ? load_res : res_r;
    end
  end

  // register file reset: entries clear through a valid mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= 32'h0;
    end else if (state_r == ST_WB && !halt_r && widx_r != 5'd0) begin
      rf_vld_r[widx_r] <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    rd_vld_r <= rf_vld_r[rf_raddr] && (state_r != ST_WB);
  end

  assign out_valid               = o_valid_r;
  assign out_next_pc             = o_npc_r;
  assign out_reg_write_valid     = o_wv_r;
  assign out_reg_write_index     = o_wi_r;
  assign out_reg_write_value     = o_wval_r;
  assign out_hi_value            = hi_r;
  assign out_lo_value            = lo_r;
  assign out_mem_write_valid     = o_mv_r;
  assign out_mem_write_address   = o_ma_r;
  assign out_mem_write_value     = o_mval_r;
  assign out_halted              = o_halt_r;
  assign out_unknown_instruction = o_unk_r;

endmodule

/* rtl/m32s_checker.sv */
// checker: port-level properties of the instruction step core, with its bind
module m32s_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_halted,
  input logic        out_reg_write_valid,
  input logic [4:0]  out_reg_write_index,
  input logic        out_mem_write_valid,
  input logic [31:0] out_mem_write_address
);

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while result pending");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped under stall");

  a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reg_write_valid |-> out_reg_write_index != 5'd0)
    else $error("write to register zero reported");

  a_store_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mem_write_valid |-> out_mem_write_address[1:0] == 2'b00)
    else $error("unaligned store address");

  a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_halted |-> !out_reg_write_valid && !out_mem_write_valid)
    else $error("write after halt");

endmodule

bind mips32_instruction_step m32s_checker u_m32s_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_halted(out_halted),
  .out_reg_write_valid(out_reg_write_valid),
  .out_reg_write_index(out_reg_write_index),
  .out_mem_write_valid(out_mem_write_valid),
  .out_mem_write_address(out_mem_write_address)
);
